>>> hdl/arptcp_pkg.sv
package arptcp_pkg;

   localparam int ARP_ENTRIES = 16;
   localparam int CONN_SLOTS  = 8;
   localparam int RX_CAPACITY = 2048;

   localparam int ARP_IDX_W  = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;
   localparam int FILL_W     = ARP_IDX_W + 1;
   localparam int CONN_IDX_W = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;
   localparam int ARP_DATA_W = 80;

   localparam logic [15:0] ETYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ARP_REPLY  = 16'd2;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  FLAG_FIN   = 8'h01;
   localparam logic [7:0]  FLAG_SYN   = 8'h02;
   localparam logic [7:0]  FLAG_ACK   = 8'h10;
   localparam logic [15:0] PORT_BASE  = 16'd49152;
   localparam logic [15:0] PORT_MASK  = 16'h3FFF;
   localparam logic [16:0] RX_LIMIT   = 17'(RX_CAPACITY);

   typedef enum logic [1:0] {
      OP_FRAME  = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_OPEN   = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IGNORED     = 4'd0,
      ST_ARP_ADDED   = 4'd1,
      ST_ARP_FULL    = 4'd2,
      ST_HIT         = 4'd3,
      ST_MISS        = 4'd4,
      ST_ESTABLISHED = 4'd5,
      ST_CLOSED      = 4'd6,
      ST_STORED      = 4'd7,
      ST_NOT_STORED  = 4'd8,
      ST_NO_ACTION   = 4'd9,
      ST_NO_CONN     = 4'd10,
      ST_OPENED      = 4'd11,
      ST_TABLE_FULL  = 4'd12
   } status_type;

   typedef enum logic [1:0] {
      PH_CLOSED      = 2'd0,
      PH_SYN_SENT    = 2'd1,
      PH_ESTABLISHED = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_ARP_SCAN,
      S_CONN_SCAN,
      S_OPEN_SCAN,
      S_UPDATE,
      S_RESPOND
   } state_type;

endpackage

>>> hdl/arptcp_if.sv
interface arptcp_req_if;
   import arptcp_pkg::*;

   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] ethertype;
   logic [15:0] arp_oper;
   logic [31:0] ip_addr;
   logic [47:0] mac_addr;
   logic [7:0]  ip_protocol;
   logic [3:0]  ip_header_words;
   logic [15:0] ip_total_len;
   logic [15:0] dest_port;
   logic [7:0]  tcp_flags;
   logic [31:0] tcp_seq;
   logic [3:0]  tcp_data_words;

   modport source (
      output valid, op, ethertype, arp_oper, ip_addr, mac_addr, ip_protocol,
             ip_header_words, ip_total_len, dest_port, tcp_flags, tcp_seq,
             tcp_data_words,
      input  ready
   );

   modport sink (
      input  valid, op, ethertype, arp_oper, ip_addr, mac_addr, ip_protocol,
             ip_header_words, ip_total_len, dest_port, tcp_flags, tcp_seq,
             tcp_data_words,
      output ready
   );
endinterface

interface arptcp_rsp_if;
   import arptcp_pkg::*;

   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [3:0]  slot;
   logic [47:0] found_mac;
   logic [31:0] ack_number;
   logic [15:0] local_port;

   modport source (
      output valid, status, slot, found_mac, ack_number, local_port,
      input  ready
   );

   modport sink (
      input  valid, status, slot, found_mac, ack_number, local_port,
      output ready
   );
endinterface

>>> hdl/arptcp_ram.sv
module arptcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/arp_cache_and_tcp_receive_table_core.sv
// Channel   Modport  Direction  Contents
// req_chan  sink     in         one operation: frame headers, ARP lookup or open
// rsp_chan  source   out        one result per operation
//
// A response becomes valid after the dispatch state, which answers ARP frames, ignored
// operations and lookups in an empty cache itself, or starts a scan of the ARP entries
// (up to 16) or of the connection slots (up to 8), plus an update state for a matching
// TCP segment. ARP entries come from a RAM with a registered read.
// The block takes one transaction at a time and is not ready until its response
// has been taken. Reset is synchronous and empties both tables at once.
module arp_cache_and_tcp_receive_table_core (
   input logic           clock,
   input logic           reset,
   arptcp_req_if.sink    req_chan,
   arptcp_rsp_if.source  rsp_chan
);
   import arptcp_pkg::*;

   state_type state_ff, state_in;

   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [ARP_IDX_W-1:0]  arp_idx_ff, arp_idx_in;
   logic [CONN_IDX_W-1:0] conn_idx_ff, conn_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   phase_type   conn_phase_ff [CONN_SLOTS];
   phase_type   conn_phase_in [CONN_SLOTS];
   logic [15:0] conn_port_ff [CONN_SLOTS];
   logic [15:0] conn_port_in [CONN_SLOTS];
   logic [31:0] conn_ack_ff [CONN_SLOTS];
   logic [31:0] conn_ack_in [CONN_SLOTS];
   logic [15:0] conn_rx_ff [CONN_SLOTS];
   logic [15:0] conn_rx_in [CONN_SLOTS];

   logic [1:0]  op_ff, op_in;
   logic [15:0] etype_ff, etype_in;
   logic [15:0] oper_ff, oper_in;
   logic [31:0] ip_ff, ip_in;
   logic [47:0] mac_ff, mac_in;
   logic [7:0]  proto_ff, proto_in;
   logic [3:0]  hdr_words_ff, hdr_words_in;
   logic [15:0] total_len_ff, total_len_in;
   logic [15:0] dport_ff, dport_in;
   logic [7:0]  flags_ff, flags_in;
   logic [31:0] seq_ff, seq_in;
   logic [3:0]  data_words_ff, data_words_in;
   logic [15:0] dlen_ff, dlen_in;

   status_type  status_ff, status_in;
   logic [3:0]  slot_ff, slot_in;
   logic [47:0] found_mac_ff, found_mac_in;
   logic [31:0] ack_num_ff, ack_num_in;
   logic [15:0] lport_ff, lport_in;

   logic                  ram_we;
   logic [ARP_IDX_W-1:0]  ram_raddr;
   logic [ARP_DATA_W-1:0] ram_rdata;
   logic [31:0]           ram_rd_ip;
   logic [47:0]           ram_rd_mac;

   logic [ARP_IDX_W+3:0]  arp_slot_wide, fill_slot_wide;
   logic [CONN_IDX_W+3:0] conn_slot_wide;
   logic [FILL_W-1:0]     arp_next;
   logic [16:0]           rx_sum;
   logic [15:0]           open_port;

   arptcp_ram #(
      .WIDTH (ARP_DATA_W),
      .DEPTH (ARP_ENTRIES)
   ) u_arp_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[ARP_IDX_W-1:0]),
      .wr_data ({ip_ff, mac_ff}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign ram_rd_ip  = ram_rdata[ARP_DATA_W-1:48];
   assign ram_rd_mac = ram_rdata[47:0];

   assign arp_slot_wide  = {4'b0000, arp_idx_ff};
   assign fill_slot_wide = {4'b0000, fill_ff[ARP_IDX_W-1:0]};
   assign conn_slot_wide = {4'b0000, conn_idx_ff};
   assign arp_next       = FILL_W'(arp_idx_ff) + FILL_W'(1);
   assign rx_sum         = {1'b0, conn_rx_ff[conn_idx_ff]} + {1'b0, dlen_ff};
   assign open_port      = PORT_BASE + (16'(fill_ff) & PORT_MASK);

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      arp_idx_in    = arp_idx_ff;
      conn_idx_in   = conn_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      conn_phase_in = conn_phase_ff;
      conn_port_in  = conn_port_ff;
      conn_ack_in   = conn_ack_ff;
      conn_rx_in    = conn_rx_ff;

      op_in         = op_ff;
      etype_in      = etype_ff;
      oper_in       = oper_ff;
      ip_in         = ip_ff;
      mac_in        = mac_ff;
      proto_in      = proto_ff;
      hdr_words_in  = hdr_words_ff;
      total_len_in  = total_len_ff;
      dport_in      = dport_ff;
      flags_in      = flags_ff;
      seq_in        = seq_ff;
      data_words_in = data_words_ff;
      dlen_in       = total_len_ff - {10'b0, hdr_words_ff, 2'b00}
                      - {10'b0, data_words_ff, 2'b00};

      status_in     = status_ff;
      slot_in       = slot_ff;
      found_mac_in  = found_mac_ff;
      ack_num_in    = ack_num_ff;
      lport_in      = lport_ff;

      ram_we         = 1'b0;
      ram_raddr      = arp_idx_ff;
      req_chan.ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            arp_idx_in     = '0;
            conn_idx_in    = '0;
            if (req_chan.valid) begin
               op_in         = req_chan.op;
               etype_in      = req_chan.ethertype;
               oper_in       = req_chan.arp_oper;
               ip_in         = req_chan.ip_addr;
               mac_in        = req_chan.mac_addr;
               proto_in      = req_chan.ip_protocol;
               hdr_words_in  = req_chan.ip_header_words;
               total_len_in  = req_chan.ip_total_len;
               dport_in      = req_chan.dest_port;
               flags_in      = req_chan.tcp_flags;
               seq_in        = req_chan.tcp_seq;
               data_words_in = req_chan.tcp_data_words;
               state_in      = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            status_in    = ST_IGNORED;
            slot_in      = '0;
            found_mac_in = '0;
            ack_num_in   = '0;
            lport_in     = '0;
            state_in     = S_RESPOND;
            rsp_valid_in = 1'b1;
            case (op_ff)
               OP_FRAME: begin
                  if (etype_ff == ETYPE_ARP) begin
                     if (oper_ff != ARP_REPLY) begin
                        status_in = ST_IGNORED;
                     end else if (fill_ff >= FILL_W'(ARP_ENTRIES)) begin
                        status_in = ST_ARP_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        fill_in   = fill_ff + FILL_W'(1);
                        status_in = ST_ARP_ADDED;
                        slot_in   = fill_slot_wide[3:0];
                     end
                  end else if (etype_ff == ETYPE_IPV4 && proto_ff == PROTO_TCP) begin
                     state_in     = S_CONN_SCAN;
                     rsp_valid_in = 1'b0;
                  end
               end
               OP_LOOKUP: begin
                  if (fill_ff == '0) begin
                     status_in = ST_MISS;
                  end else begin
                     state_in     = S_ARP_SCAN;
                     rsp_valid_in = 1'b0;
                  end
               end
               OP_OPEN: begin
                  state_in     = S_OPEN_SCAN;
                  rsp_valid_in = 1'b0;
               end
               default: begin
                  status_in = ST_IGNORED;
               end
            endcase
         end

         S_ARP_SCAN: begin
            ram_raddr = arp_next[ARP_IDX_W-1:0];
            if (ram_rd_ip == ip_ff) begin
               status_in    = ST_HIT;
               slot_in      = arp_slot_wide[3:0];
               found_mac_in = ram_rd_mac;
               rsp_valid_in = 1'b1;
               state_in     = S_RESPOND;
            end else if (arp_next >= fill_ff) begin
               status_in    = ST_MISS;
               rsp_valid_in = 1'b1;
               state_in     = S_RESPOND;
            end else begin
               arp_idx_in = arp_next[ARP_IDX_W-1:0];
            end
         end

         S_CONN_SCAN: begin
            if (conn_port_ff[conn_idx_ff] == dport_ff) begin
               state_in = S_UPDATE;
            end else if (conn_idx_ff == CONN_IDX_W'(CONN_SLOTS - 1)) begin
               status_in    = ST_NO_CONN;
               rsp_valid_in = 1'b1;
               state_in     = S_RESPOND;
            end else begin
               conn_idx_in = conn_idx_ff + CONN_IDX_W'(1);
            end
         end

         S_OPEN_SCAN: begin
            if (conn_phase_ff[conn_idx_ff] == PH_CLOSED) begin
               conn_port_in[conn_idx_ff]  = open_port;
               conn_ack_in[conn_idx_ff]   = '0;
               conn_rx_in[conn_idx_ff]    = '0;
               conn_phase_in[conn_idx_ff] = PH_SYN_SENT;
               status_in    = ST_OPENED;
               slot_in      = conn_slot_wide[3:0];
               lport_in     = open_port;
               rsp_valid_in = 1'b1;
               state_in     = S_RESPOND;
            end else if (conn_idx_ff == CONN_IDX_W'(CONN_SLOTS - 1)) begin
               status_in    = ST_TABLE_FULL;
               rsp_valid_in = 1'b1;
               state_in     = S_RESPOND;
            end else begin
               conn_idx_in = conn_idx_ff + CONN_IDX_W'(1);
            end
         end

         S_UPDATE: begin
            slot_in      = conn_slot_wide[3:0];
            ack_num_in   = conn_ack_ff[conn_idx_ff];
            rsp_valid_in = 1'b1;
            state_in     = S_RESPOND;
            if ((flags_ff & FLAG_SYN) != '0 && (flags_ff & FLAG_ACK) != '0) begin
               conn_phase_in[conn_idx_ff] = PH_ESTABLISHED;
               conn_ack_in[conn_idx_ff]   = seq_ff + 32'd1;
               ack_num_in = seq_ff + 32'd1;
               status_in  = ST_ESTABLISHED;
            end else if ((flags_ff & FLAG_FIN) != '0) begin
               conn_phase_in[conn_idx_ff] = PH_CLOSED;
               status_in = ST_CLOSED;
            end else if ((flags_ff & FLAG_ACK) != '0) begin
               conn_ack_in[conn_idx_ff] = seq_ff + {16'b0, dlen_ff};
               ack_num_in = seq_ff + {16'b0, dlen_ff};
               if (dlen_ff != '0 && rx_sum < RX_LIMIT) begin
                  conn_rx_in[conn_idx_ff] = rx_sum[15:0];
                  status_in = ST_STORED;
               end else begin
                  status_in = ST_NOT_STORED;
               end
            end else begin
               status_in = ST_NO_ACTION;
            end
         end

         S_RESPOND: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         arp_idx_ff   <= '0;
         conn_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CONN_SLOTS; i++) begin
            conn_phase_ff[i] <= PH_CLOSED;
            conn_port_ff[i]  <= '0;
            conn_ack_ff[i]   <= '0;
            conn_rx_ff[i]    <= '0;
         end
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         arp_idx_ff    <= arp_idx_in;
         conn_idx_ff   <= conn_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         conn_phase_ff <= conn_phase_in;
         conn_port_ff  <= conn_port_in;
         conn_ack_ff   <= conn_ack_in;
         conn_rx_ff    <= conn_rx_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      etype_ff      <= etype_in;
      oper_ff       <= oper_in;
      ip_ff         <= ip_in;
      mac_ff        <= mac_in;
      proto_ff      <= proto_in;
      hdr_words_ff  <= hdr_words_in;
      total_len_ff  <= total_len_in;
      dport_ff      <= dport_in;
      flags_ff      <= flags_in;
      seq_ff        <= seq_in;
      data_words_ff <= data_words_in;
      dlen_ff       <= dlen_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      found_mac_ff  <= found_mac_in;
      ack_num_ff    <= ack_num_in;
      lport_ff      <= lport_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.slot       = slot_ff;
   assign rsp_chan.found_mac  = found_mac_ff;
   assign rsp_chan.ack_number = ack_num_ff;
   assign rsp_chan.local_port = lport_ff;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import arptcp_pkg::*;

   localparam logic [1:0]  OP_UNKNOWN  = 2'd3;
   localparam logic [15:0] FIRST_PORT  = PORT_BASE + 16'd1;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          RANDOM_OPS  = 534;
   localparam int          HOLD_CYCLES = 400;
   localparam int          TAIL_CYCLES = 40;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] ethertype;
      logic [15:0] arp_oper;
      logic [31:0] ip_addr;
      logic [47:0] mac_addr;
      logic [7:0]  ip_protocol;
      logic [3:0]  ip_header_words;
      logic [15:0] ip_total_len;
      logic [15:0] dest_port;
      logic [7:0]  tcp_flags;
      logic [31:0] tcp_seq;
      logic [3:0]  tcp_data_words;
   } op_item_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [3:0]  slot;
      logic [47:0] found_mac;
      logic [31:0] ack_number;
      logic [15:0] local_port;
   } outcome_type;

   typedef struct {
      op_item_type item;
      bit          typed;
      outcome_type want;
   } plan_row_type;

   logic clock;
   logic reset;

   arptcp_req_if req ();
   arptcp_rsp_if rsp ();

   arp_cache_and_tcp_receive_table_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req.sink),
      .rsp_chan (rsp.source)
   );

   logic [31:0] arp_ip_m   [ARP_ENTRIES];
   logic [47:0] arp_mac_m  [ARP_ENTRIES];
   int          arp_count;
   phase_type   conn_phase_m [CONN_SLOTS];
   logic [15:0] conn_port_m  [CONN_SLOTS];
   logic [31:0] conn_ack_m   [CONN_SLOTS];
   logic [15:0] conn_rx_m    [CONN_SLOTS];

   outcome_type  outcome_q [$];
   plan_row_type plan [$];
   bit           cur_typed;
   outcome_type  cur_want;
   int           mismatches;
   int           cycle_count;
   int           send_idle_pct;
   int           recv_idle_pct;
   bit           holdoff_go;
   logic         hold_rsp;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic outcome_type table_outcome(op_item_type t);
      outcome_type o;
      int          hit;
      int          i;
      logic [15:0] dlen;
      o = '0;
      hit = -1;
      case (t.op)
         OP_FRAME: begin
            if (t.ethertype == ETYPE_ARP) begin
               if (t.arp_oper != ARP_REPLY) begin
                  o.status = ST_IGNORED;
               end else if (arp_count >= ARP_ENTRIES) begin
                  o.status = ST_ARP_FULL;
               end else begin
                  arp_ip_m[arp_count] = t.ip_addr;
                  arp_mac_m[arp_count] = t.mac_addr;
                  o.status = ST_ARP_ADDED;
                  o.slot = 4'(arp_count);
                  arp_count++;
               end
            end else if (t.ethertype == ETYPE_IPV4 && t.ip_protocol == PROTO_TCP) begin
               for (i = CONN_SLOTS - 1; i >= 0; i--)
                  if (conn_port_m[i] == t.dest_port) hit = i;
               if (hit < 0) begin
                  o.status = ST_NO_CONN;
               end else begin
                  o.slot = 4'(hit);
                  if ((t.tcp_flags & FLAG_SYN) != 0 && (t.tcp_flags & FLAG_ACK) != 0) begin
                     conn_phase_m[hit] = PH_ESTABLISHED;
                     conn_ack_m[hit] = t.tcp_seq + 32'd1;
                     o.status = ST_ESTABLISHED;
                  end else if ((t.tcp_flags & FLAG_FIN) != 0) begin
                     conn_phase_m[hit] = PH_CLOSED;
                     o.status = ST_CLOSED;
                  end else if ((t.tcp_flags & FLAG_ACK) != 0) begin
                     dlen = t.ip_total_len - {10'b0, t.ip_header_words, 2'b00}
                            - {10'b0, t.tcp_data_words, 2'b00};
                     if (dlen != 16'd0 && int'(conn_rx_m[hit]) + int'(dlen) < RX_CAPACITY) begin
                        conn_rx_m[hit] = conn_rx_m[hit] + dlen;
                        o.status = ST_STORED;
                     end else begin
                        o.status = ST_NOT_STORED;
                     end
                     conn_ack_m[hit] = t.tcp_seq + 32'(dlen);
                  end else begin
                     o.status = ST_NO_ACTION;
                  end
                  o.ack_number = conn_ack_m[hit];
               end
            end else begin
               o.status = ST_IGNORED;
            end
         end
         OP_LOOKUP: begin
            for (i = 0; i < arp_count; i++)
               if (hit < 0 && arp_ip_m[i] == t.ip_addr) hit = i;
            if (hit < 0) begin
               o.status = ST_MISS;
            end else begin
               o.status = ST_HIT;
               o.slot = 4'(hit);
               o.found_mac = arp_mac_m[hit];
            end
         end
         OP_OPEN: begin
            for (i = CONN_SLOTS - 1; i >= 0; i--)
               if (conn_phase_m[i] == PH_CLOSED) hit = i;
            if (hit < 0) begin
               o.status = ST_TABLE_FULL;
            end else begin
               conn_port_m[hit] = PORT_BASE + (16'(arp_count) & PORT_MASK);
               conn_ack_m[hit] = '0;
               conn_rx_m[hit] = '0;
               conn_phase_m[hit] = PH_SYN_SENT;
               o.status = ST_OPENED;
               o.slot = 4'(hit);
               o.local_port = conn_port_m[hit];
            end
         end
         default: o.status = ST_IGNORED;
      endcase
      return o;
   endfunction

   function automatic op_item_type mk(logic [1:0] op, logic [15:0] etype, logic [15:0] oper,
                                      logic [7:0] proto, logic [31:0] ip, logic [47:0] mac);
      op_item_type t;
      t = '0;
      t.op = op;
      t.ethertype = etype;
      t.arp_oper = oper;
      t.ip_protocol = proto;
      t.ip_addr = ip;
      t.mac_addr = mac;
      return t;
   endfunction

   function automatic op_item_type tcp_seg(logic [15:0] port, logic [7:0] flags,
                                           logic [31:0] seq, logic [15:0] total,
                                           logic [3:0] ihl, logic [3:0] doff);
      op_item_type t;
      t = mk(OP_FRAME, ETYPE_IPV4, '0, PROTO_TCP, '0, '0);
      t.dest_port = port;
      t.tcp_flags = flags;
      t.tcp_seq = seq;
      t.ip_total_len = total;
      t.ip_header_words = ihl;
      t.tcp_data_words = doff;
      return t;
   endfunction

   function automatic outcome_type res(status_type st, logic [3:0] slot, logic [47:0] mac,
                                       logic [31:0] ack, logic [15:0] port);
      outcome_type o;
      o.status = st;
      o.slot = slot;
      o.found_mac = mac;
      o.ack_number = ack;
      o.local_port = port;
      return o;
   endfunction

   function automatic op_item_type random_op();
      op_item_type  t;
      logic [223:0] noise;
      int           pick;
      int           sub;
      int           pay;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      t = noise[$bits(op_item_type)-1:0];
      pick = $urandom_range(99);
      if (pick < 30) begin
         t.op = OP_FRAME;
         t.ethertype = ETYPE_IPV4;
         t.ip_protocol = PROTO_TCP;
         sub = $urandom_range(99);
         if (sub < 70) t.dest_port = conn_port_m[$urandom_range(CONN_SLOTS - 1)];
         else if (sub < 85) t.dest_port = PORT_BASE + 16'($urandom_range(ARP_ENTRIES));
         sub = $urandom_range(9);
         if (sub < 2) t.tcp_flags = FLAG_SYN | FLAG_ACK | (t.tcp_flags & 8'hEC);
         else if (sub < 3) t.tcp_flags = FLAG_FIN | (t.tcp_flags & 8'hED);
         else if (sub < 7) t.tcp_flags = FLAG_ACK | (t.tcp_flags & 8'hEC);
         else if (sub < 8) t.tcp_flags = t.tcp_flags & 8'hEC;
         sub = $urandom_range(99);
         if (sub < 60) pay = $urandom_range(1, 400);
         else if (sub < 75) pay = 0;
         else pay = -1;
         if (pay >= 0)
            t.ip_total_len = 16'(int'(t.ip_header_words) * 4 + int'(t.tcp_data_words) * 4 + pay);
      end else if (pick < 45) begin
         t.op = OP_OPEN;
      end else if (pick < 60) begin
         t.op = OP_FRAME;
         t.ethertype = ETYPE_ARP;
         t.arp_oper = ARP_REPLY;
         if (arp_count > 0 && $urandom_range(3) == 0)
            t.ip_addr = arp_ip_m[$urandom_range(arp_count - 1)];
      end else if (pick < 75) begin
         t.op = OP_LOOKUP;
         if (arp_count > 0 && $urandom_range(9) < 6)
            t.ip_addr = arp_ip_m[$urandom_range(arp_count - 1)];
      end else if (pick < 85) begin
         t.op = OP_FRAME;
         sub = $urandom_range(2);
         if (sub == 0) begin
            t.ethertype = ETYPE_ARP;
            if (t.arp_oper == ARP_REPLY) t.arp_oper = 16'd1;
         end else if (sub == 1) begin
            t.ethertype = ETYPE_IPV4;
            if (t.ip_protocol == PROTO_TCP) t.ip_protocol = 8'd17;
         end
      end else if (pick < 90) begin
         t.op = OP_UNKNOWN;
      end
      return t;
   endfunction

   task automatic offer(op_item_type t, bit typed, outcome_type want);
      req.op <= t.op;
      req.ethertype <= t.ethertype;
      req.arp_oper <= t.arp_oper;
      req.ip_addr <= t.ip_addr;
      req.mac_addr <= t.mac_addr;
      req.ip_protocol <= t.ip_protocol;
      req.ip_header_words <= t.ip_header_words;
      req.ip_total_len <= t.ip_total_len;
      req.dest_port <= t.dest_port;
      req.tcp_flags <= t.tcp_flags;
      req.tcp_seq <= t.tcp_seq;
      req.tcp_data_words <= t.tcp_data_words;
      cur_typed <= typed;
      cur_want <= want;
      req.valid <= 1'b1;
      do @(posedge clock); while (req.ready !== 1'b1);
   endtask

   task automatic idle_after();
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 30) gap++;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_rsp
      outcome_type got;
      outcome_type want;
      op_item_type seen;
      if (!reset) begin
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            got = {rsp.status, rsp.slot, rsp.found_mac, rsp.ack_number, rsp.local_port};
            if (outcome_q.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected transaction: status %0d slot %0d mac %h ack %h port %h",
                           got.status, got.slot, got.found_mac, got.ack_number, got.local_port);
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.found_mac !== want.found_mac || got.ack_number !== want.ack_number ||
                   got.local_port !== want.local_port) begin
                  if (mismatches < 10)
                     $display("mismatch: expected status %0d slot %0d mac %h ack %h port %h, %s",
                              want.status, want.slot, want.found_mac, want.ack_number,
                              want.local_port,
                              $sformatf("got status %0d slot %0d mac %h ack %h port %h",
                                        got.status, got.slot, got.found_mac, got.ack_number,
                                        got.local_port));
                  mismatches++;
               end
            end
         end
         if (req.valid === 1'b1 && req.ready === 1'b1) begin
            seen = {req.op, req.ethertype, req.arp_oper, req.ip_addr, req.mac_addr,
                    req.ip_protocol, req.ip_header_words, req.ip_total_len, req.dest_port,
                    req.tcp_flags, req.tcp_seq, req.tcp_data_words};
            want = table_outcome(seen);
            if (cur_typed) want = cur_want;
            outcome_q.push_back(want);
         end
      end
   end

   initial begin : rsp_holdoff
      int held;
      hold_rsp = 1'b0;
      wait (holdoff_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      held = 0;
      while (held < HOLD_CYCLES) begin
         @(posedge clock);
         held++;
      end
      hold_rsp <= 1'b0;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** arp_cache_and_tcp_receive_table_core: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int i;
      int k;
      int p;
      clock = 1'b0;
      reset = 1'b1;
      rsp.ready = 1'b0;
      req.valid <= 1'b0;
      req.op <= '0;
      req.ethertype <= '0;
      req.arp_oper <= '0;
      req.ip_addr <= '0;
      req.mac_addr <= '0;
      req.ip_protocol <= '0;
      req.ip_header_words <= '0;
      req.ip_total_len <= '0;
      req.dest_port <= '0;
      req.tcp_flags <= '0;
      req.tcp_seq <= '0;
      req.tcp_data_words <= '0;
      cur_typed <= 1'b0;
      cur_want <= '0;
      mismatches = 0;
      holdoff_go = 1'b0;
      send_idle_pct = 34;
      recv_idle_pct = 46;
      arp_count = 0;
      for (i = 0; i < ARP_ENTRIES; i++) begin
         arp_ip_m[i] = '0;
         arp_mac_m[i] = '0;
      end
      for (i = 0; i < CONN_SLOTS; i++) begin
         conn_phase_m[i] = PH_CLOSED;
         conn_port_m[i] = '0;
         conn_ack_m[i] = '0;
         conn_rx_m[i] = '0;
      end

      plan.push_back('{mk(OP_LOOKUP, '0, '0, '0, '0, '0), 1'b1,
                       res(ST_MISS, '0, '0, '0, '0)});
      plan.push_back('{tcp_seg('0, '0, '0, '0, '0, '0), 1'b1,
                       res(ST_NO_ACTION, '0, '0, '0, '0)});
      plan.push_back('{'1, 1'b1, res(ST_IGNORED, '0, '0, '0, '0)});
      plan.push_back('{mk(OP_FRAME, ETYPE_ARP, 16'd1, '0, 32'h0A000001, 48'h1), 1'b1,
                       res(ST_IGNORED, '0, '0, '0, '0)});
      plan.push_back('{mk(OP_FRAME, ETYPE_ARP, ARP_REPLY, '0, '1, '1), 1'b1,
                       res(ST_ARP_ADDED, '0, '0, '0, '0)});
      plan.push_back('{mk(OP_FRAME, ETYPE_IPV4, '0, 8'd17, '0, '0), 1'b1,
                       res(ST_IGNORED, '0, '0, '0, '0)});
      plan.push_back('{mk(OP_FRAME, 16'hFFFF, ARP_REPLY, PROTO_TCP, '0, '0), 1'b1,
                       res(ST_IGNORED, '0, '0, '0, '0)});
      plan.push_back('{mk(OP_LOOKUP, '0, '0, '0, '1, '0), 1'b1,
                       res(ST_HIT, '0, '1, '0, '0)});
      plan.push_back('{mk(OP_OPEN, '0, '0, '0, '0, '0), 1'b1,
                       res(ST_OPENED, '0, '0, '0, FIRST_PORT)});
      plan.push_back('{tcp_seg(FIRST_PORT, FLAG_SYN | FLAG_ACK, '1, 16'd40, 4'd5, 4'd5), 1'b1,
                       res(ST_ESTABLISHED, '0, '0, '0, '0)});
      plan.push_back('{tcp_seg(FIRST_PORT, FLAG_ACK, 32'd10, 16'd100, 4'd5, 4'd5), 1'b0, '0});
      plan.push_back('{tcp_seg(FIRST_PORT, FLAG_ACK, 32'h1234, 16'd40, 4'd5, 4'd5), 1'b0, '0});
      plan.push_back('{tcp_seg(FIRST_PORT, FLAG_ACK, '0, '0, 4'd15, 4'd15), 1'b0, '0});
      plan.push_back('{tcp_seg(FIRST_PORT, FLAG_ACK, '1, 16'hFFFF, '0, '0), 1'b0, '0});
      plan.push_back('{tcp_seg(FIRST_PORT, 8'hFF, 32'h80000000, '0, '0, '0), 1'b0, '0});
      plan.push_back('{tcp_seg(FIRST_PORT, FLAG_FIN | FLAG_ACK, '0, 16'd40, 4'd5, 4'd5),
                       1'b0, '0});
      plan.push_back('{tcp_seg(16'hFFFF, FLAG_ACK, '0, 16'd40, 4'd5, 4'd5), 1'b1,
                       res(ST_NO_CONN, '0, '0, '0, '0)});
      for (k = 0; k < CONN_SLOTS; k++)
         plan.push_back('{mk(OP_OPEN, '0, '0, '0, '0, '0), 1'b1,
                          res(ST_OPENED, 4'(k), '0, '0, FIRST_PORT)});
      plan.push_back('{mk(OP_OPEN, '0, '0, '0, '0, '0), 1'b1,
                       res(ST_TABLE_FULL, '0, '0, '0, '0)});

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k]) begin
         offer(plan[k].item, plan[k].typed, plan[k].want);
         idle_after();
      end
      drain();

      for (p = 0; p < 3; p++) begin
         if (p == 0) begin
            send_idle_pct = 34;
            recv_idle_pct = 46;
         end else if (p == 1) begin
            send_idle_pct = 46;
            recv_idle_pct = 34;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (i = 0; i < RANDOM_OPS; i++) begin
            offer(random_op(), 1'b0, '0);
            idle_after();
            if (p == 0 && i == 200) holdoff_go = 1'b1;
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outcome_q.size() == 0) begin
         $display("** arp_cache_and_tcp_receive_table_core: PASSED **");
      end else begin
         $display("** arp_cache_and_tcp_receive_table_core: FAILED **");
      end
      $finish;
   end

endmodule
